[rtl/core/assert_macros.svh]
// Assertion macros used by the top level of the key frame encoder.
// Simulation builds get concurrent assertions; SYNTH builds get empty bodies.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// When cond holds, expr must hold on the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expr)

`endif

`endif

[rtl/core/pke_pkg.sv]
// Shared types, scan code constants and frame helpers for the key frame encoder.
// No dependencies.
package pke_pkg;

    localparam logic [7:0] CODE_EXT       = 8'hE0;
    localparam logic [7:0] CODE_EXT1      = 8'hE1;
    localparam logic [7:0] CODE_BREAK     = 8'hF0;
    localparam logic [7:0] CODE_PRTSC_PRE = 8'h12;
    localparam logic [7:0] CODE_PRTSC_KEY = 8'h7C;
    localparam logic [7:0] CODE_PAUSE_A   = 8'h14;
    localparam logic [7:0] CODE_PAUSE_B   = 8'h77;
    localparam logic [7:0] CODE_NONE      = 8'h00;

    localparam int FRAME_W = 11;
    localparam int IDX_W   = 3;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_PAIR   = 2'd1,
        KIND_PRTSC  = 2'd2,
        KIND_PAUSE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        SEQ_SINGLE_MAKE,
        SEQ_SINGLE_BREAK,
        SEQ_PAIR_MAKE,
        SEQ_PAIR_BREAK,
        SEQ_PRTSC_MAKE,
        SEQ_PRTSC_BREAK,
        SEQ_PAUSE_MAKE
    } seq_t;

    typedef struct packed {
        seq_t       seq;
        logic [7:0] prefix;
        logic [7:0] code;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Index of the final byte of a sequence.
    function automatic logic [IDX_W-1:0] pke_last_idx(input seq_t seq);
        logic [IDX_W-1:0] r;
        case (seq)
            SEQ_SINGLE_MAKE:  r = 3'd0;
            SEQ_SINGLE_BREAK: r = 3'd1;
            SEQ_PAIR_MAKE:    r = 3'd1;
            SEQ_PAIR_BREAK:   r = 3'd2;
            SEQ_PRTSC_MAKE:   r = 3'd3;
            SEQ_PRTSC_BREAK:  r = 3'd5;
            SEQ_PAUSE_MAKE:   r = 3'd7;
            default:          r = 3'd0;
        endcase
        return r;
    endfunction

    // Byte at position idx of a sequence.
    function automatic logic [7:0] pke_byte(input desc_t d, input logic [IDX_W-1:0] idx);
        logic [7:0] r;
        r = d.code;
        case (d.seq)
            SEQ_SINGLE_MAKE:  r = d.code;
            SEQ_SINGLE_BREAK: r = (idx == 3'd0) ? CODE_BREAK : d.code;
            SEQ_PAIR_MAKE:    r = (idx == 3'd0) ? d.prefix : d.code;
            SEQ_PAIR_BREAK:
            begin
                case (idx)
                    3'd0:    r = d.prefix;
                    3'd1:    r = CODE_BREAK;
                    default: r = d.code;
                endcase
            end
            SEQ_PRTSC_MAKE:
            begin
                case (idx)
                    3'd0:    r = CODE_EXT;
                    3'd1:    r = CODE_PRTSC_PRE;
                    3'd2:    r = CODE_EXT;
                    default: r = CODE_PRTSC_KEY;
                endcase
            end
            SEQ_PRTSC_BREAK:
            begin
                case (idx)
                    3'd0:    r = CODE_EXT;
                    3'd1:    r = CODE_BREAK;
                    3'd2:    r = CODE_PRTSC_KEY;
                    3'd3:    r = CODE_EXT;
                    3'd4:    r = CODE_BREAK;
                    default: r = CODE_PRTSC_PRE;
                endcase
            end
            SEQ_PAUSE_MAKE:
            begin
                case (idx)
                    3'd0:    r = CODE_EXT1;
                    3'd1:    r = CODE_PAUSE_A;
                    3'd2:    r = CODE_PAUSE_B;
                    3'd3:    r = CODE_EXT1;
                    3'd4:    r = CODE_BREAK;
                    3'd5:    r = CODE_PAUSE_A;
                    3'd6:    r = CODE_BREAK;
                    default: r = CODE_PAUSE_B;
                endcase
            end
            default: r = d.code;
        endcase
        return r;
    endfunction

    // Start 0, data MSB first, odd parity, stop 1.
    function automatic logic [FRAME_W-1:0] pke_frame(input logic [7:0] b);
        return {1'b1, ~(^b), b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7], 1'b0};
    endfunction

endpackage

[rtl/core/pke_front.sv]
// Front stage of the key frame encoder: accept and classify key events.
// Depends on pke_pkg.
module pke_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_kind,
    input  logic [7:0]       in_prefix,
    input  logic [7:0]       in_code,
    input  logic             in_release,
    input  pke_pkg::q_stat_t q_stat,
    output logic             push,
    output pke_pkg::desc_t   push_desc
);
    import pke_pkg::*;

    logic  valid_reg, valid_next;
    desc_t desc_reg, desc_next;
    logic  accept;
    logic  emits;
    seq_t  seq_cls;

    // Classify the event; events with no bytes are dropped here.
    always_comb
    begin
        emits   = 1'b1;
        seq_cls = SEQ_SINGLE_MAKE;
        case (kind_t'(in_kind))
            KIND_SINGLE:
            begin
                emits   = (in_code != CODE_NONE);
                seq_cls = in_release ? SEQ_SINGLE_BREAK : SEQ_SINGLE_MAKE;
            end
            KIND_PAIR:  seq_cls = in_release ? SEQ_PAIR_BREAK : SEQ_PAIR_MAKE;
            KIND_PRTSC: seq_cls = in_release ? SEQ_PRTSC_BREAK : SEQ_PRTSC_MAKE;
            KIND_PAUSE:
            begin
                emits   = ~in_release;
                seq_cls = SEQ_PAUSE_MAKE;
            end
            default:    emits = 1'b0;
        endcase
    end

    assign push     = valid_reg & ~q_stat.full;
    assign in_ready = ~valid_reg | ~q_stat.full;
    assign accept   = in_valid & in_ready;
    assign push_desc = desc_reg;

    always_comb
    begin
        valid_next = valid_reg;
        desc_next  = desc_reg;
        if (accept)
        begin
            valid_next       = emits;
            desc_next.seq    = seq_cls;
            desc_next.prefix = in_prefix;
            desc_next.code   = in_code;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule

[rtl/core/pke_queue.sv]
// Descriptor queue between the front and back stages of the key frame encoder.
// Depends on pke_pkg.
module pke_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pke_pkg::desc_t   push_desc,
    input  logic             pop,
    output pke_pkg::desc_t   head,
    output pke_pkg::q_stat_t q_stat
);
    import pke_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push & ~q_stat.full;
    assign do_pop       = pop & ~q_stat.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push & ~do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop & ~do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[rtl/core/pke_back.sv]
// Back stage of the key frame encoder: walk each sequence, one frame per transfer.
// Depends on pke_pkg.
module pke_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pke_pkg::desc_t                head,
    input  pke_pkg::q_stat_t              q_stat,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pke_pkg::FRAME_W-1:0]   out_frame,
    output logic [7:0]                    out_byte,
    output logic                          out_last
);
    import pke_pkg::*;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               valid_reg, valid_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [7:0]         byte_reg, byte_next;
    logic               last_reg, last_next;
    logic               out_free;
    logic               emit;
    logic               at_end;
    logic [7:0]         cur_byte;

    assign out_free = ~valid_reg | out_ready;
    assign emit     = out_free & ~q_stat.empty;
    assign at_end   = (idx_reg == pke_last_idx(head.seq));
    assign pop      = emit & at_end;
    assign cur_byte = pke_byte(head, idx_reg);

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        frame_next = frame_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            frame_next = pke_frame(cur_byte);
            byte_next  = cur_byte;
            last_next  = at_end;
            idx_next   = at_end ? '0 : idx_reg + 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_frame = frame_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

[rtl/core/ps2_key_frame_encoder.sv]
// Top level of the PS/2 scan code set 2 key frame encoder.
// Depends on pke_pkg, pke_front, pke_queue, pke_back and assert_macros.svh.
//
// Takes one key event per transfer on the slave stream and sends its set 2
// scan code bytes on the master stream, one 11-bit PS/2 frame per transfer
// (start 0, data MSB first, odd parity, stop 1), with tlast on the final
// byte of each event. Single codes get F0 in front on release; prefixed
// codes send prefix, F0 on release, then code; Print Screen and Pause send
// their fixed sequences. Pause release and a single code of zero send
// nothing. An event sends one frame per byte (1 to 8 bytes) from the
// back-end sequencer, which emits one byte per clock while the output is free;
// events with no bytes still take one input transfer. The first frame reaches
// the master stream through the front register, the descriptor queue and the
// output register when the output is free, and can transfer at the next edge. The front
// register and a QUEUE_DEPTH-entry descriptor queue let new events be
// taken while earlier ones are still being sent.
`include "assert_macros.svh"

module ps2_key_frame_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] prefix_byte, [15:8] scan_code
    input  logic [2:0]  s_axis_tuser,   // [1:0] key_kind, [2] release_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [10:0] frame, [18:11] byte_value, [23:19] zero
    output logic        m_axis_tlast    // last
);
    import pke_pkg::*;

    q_stat_t            q_stat;
    desc_t              push_desc;
    desc_t              head;
    logic               push;
    logic               pop;
    logic [FRAME_W-1:0] frame;
    logic [7:0]         byte_value;

    // Classify the event and hold it until the queue has room.
    pke_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser[1:0]),
        .in_prefix  (s_axis_tdata[7:0]),
        .in_code    (s_axis_tdata[15:8]),
        .in_release (s_axis_tuser[2]),
        .q_stat     (q_stat),
        .push       (push),
        .push_desc  (push_desc)
    );

    // Decouple the front from the frame sequencer.
    pke_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // Walk the head descriptor, one frame per output transfer; drop it on its last byte.
    pke_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_frame (frame),
        .out_byte  (byte_value),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, byte_value, frame};

    `ASSERT_ALWAYS(a_queue_state, clk, rst_n, !(q_stat.full && q_stat.empty))
    `ASSERT_ALWAYS(a_pop_nonempty, clk, rst_n, !(pop && q_stat.empty))
    `ASSERT_NEXT(a_pop_marks_last, clk, rst_n, pop, m_axis_tvalid && m_axis_tlast)

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for ps2_key_frame_encoder: directed key events, then random ones.
// Each event transfer is expanded into expected scan code frames and compared in order.
// Depends on pke_pkg and the encoder RTL.
module tb_top;
    import pke_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 11;
    localparam int RAND_EVENTS = 300;   // random events that send at least one byte
    localparam int QUIET_AFTER = 200;   // no idling once this many have gone
    localparam int DRAIN_CYC   = 24;
    localparam int LIMIT_CYC   = 500000;
    localparam int ERR_PRINTS  = 40;

    typedef struct {
        logic [10:0] frame;
        logic [7:0]  byte_v;
        logic        last;
    } key_frame_t;

    // One directed event; lit_n < 0 means "take the byte sequence from the predictor",
    // otherwise the first lit_n bytes of lit (most significant first) are the answer.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  pre;
        logic [7:0]  code;
        logic        rel;
        int          lit_n;
        logic [63:0] lit;
    } key_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [7:0] prefix_byte, [15:8] scan_code
    logic [2:0]  s_axis_tuser = '0;     // [1:0] key_kind, [2] release_req
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [10:0] frame, [18:11] byte_value, [23:19] zero
    logic        m_axis_tlast;

    key_frame_t  frames_due[$];
    int          err_count = 0;
    int          frames_seen = 0;
    int          events_taken = 0;
    int          kind_taken[4] = '{0, 0, 0, 0};
    bit          quiet = 1'b0;          // set for the final stretch: no idling anywhere

    // Literal answer of the event now on the slave stream (lit_n < 0: none)
    int          cur_lit_n = -1;
    logic [63:0] cur_lit = '0;

    key_row_t dir_rows [20] = '{
        '{KIND_SINGLE, 8'h00, 8'h1C, 1'b0,  1, 64'h1C},               // first after reset
        '{KIND_SINGLE, 8'h00, 8'h00, 1'b0,  0, 64'h0},                // unmapped make
        '{KIND_SINGLE, 8'hFF, 8'h00, 1'b1,  0, 64'h0},                // unmapped break
        '{KIND_SINGLE, 8'h00, 8'hFF, 1'b0,  1, 64'hFF},
        '{KIND_SINGLE, 8'h00, 8'h01, 1'b1,  2, 64'hF001},
        '{KIND_SINGLE, 8'h00, 8'h80, 1'b1, -1, 64'h0},
        '{KIND_PAIR,   8'hE0, 8'h00, 1'b0,  2, 64'hE000},             // zero code still sent
        '{KIND_PAIR,   8'h00, 8'h00, 1'b1,  3, 64'h00F000},
        '{KIND_PAIR,   8'hFF, 8'hFF, 1'b1,  3, 64'hFFF0FF},
        '{KIND_PAIR,   8'hE0, 8'h75, 1'b0, -1, 64'h0},
        '{KIND_PAIR,   8'h5A, 8'hA5, 1'b1, -1, 64'h0},
        '{KIND_PRTSC,  8'hFF, 8'hFF, 1'b0,  4, 64'hE012E07C},
        '{KIND_PRTSC,  8'h00, 8'h00, 1'b1,  6, 64'hE0F07CE0F012},
        '{KIND_PAUSE,  8'hAA, 8'h55, 1'b0,  8, 64'hE11477E1F014F077},
        '{KIND_PAUSE,  8'hFF, 8'hFF, 1'b1,  0, 64'h0},                // pause break is silent
        '{KIND_SINGLE, 8'hFF, 8'h55, 1'b0, -1, 64'h0},                // prefix ignored
        '{KIND_PAUSE,  8'h00, 8'h00, 1'b0, -1, 64'h0},
        '{KIND_PRTSC,  8'h5A, 8'hA5, 1'b1, -1, 64'h0},
        '{KIND_SINGLE, 8'h00, 8'hF0, 1'b0, -1, 64'h0},
        '{KIND_PAIR,   8'h01, 8'h80, 1'b0, -1, 64'h0}
    };

    ps2_key_frame_encoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Start bit low, data bits MSB first, odd parity, stop bit high
    function automatic logic [10:0] ps2_frame_of(input logic [7:0] b);
        logic [10:0] f;
        f = 11'b100_0000_0000;
        for (int i = 0; i < 8; i++)
            f[i + 1] = b[7 - i];
        f[9] = ~(^b);
        return f;
    endfunction

    // Scan code set 2 bytes of one key event; returns how many bytes it sends
    function automatic int scan_sequence(input kind_t kind, input logic [7:0] pre,
                                         input logic [7:0] code, input logic rel,
                                         output logic [7:0] seq [8]);
        int n;
        n = 0;
        for (int i = 0; i < 8; i++)
            seq[i] = '0;
        case (kind)
            KIND_PRTSC:
            begin
                if (rel)
                begin
                    seq = '{CODE_EXT, CODE_BREAK, CODE_PRTSC_KEY, CODE_EXT, CODE_BREAK,
                            CODE_PRTSC_PRE, 8'h00, 8'h00};
                    n = 6;
                end
                else
                begin
                    seq = '{CODE_EXT, CODE_PRTSC_PRE, CODE_EXT, CODE_PRTSC_KEY,
                            8'h00, 8'h00, 8'h00, 8'h00};
                    n = 4;
                end
            end
            KIND_PAUSE:
            begin
                // only the make has a sequence; the break sends nothing
                if (!rel)
                begin
                    seq = '{CODE_EXT1, CODE_PAUSE_A, CODE_PAUSE_B, CODE_EXT1, CODE_BREAK,
                            CODE_PAUSE_A, CODE_BREAK, CODE_PAUSE_B};
                    n = 8;
                end
            end
            KIND_PAIR:
            begin
                seq[n] = pre;
                n++;
                if (rel)
                begin
                    seq[n] = CODE_BREAK;
                    n++;
                end
                seq[n] = code;
                n++;
            end
            default:
            begin
                if (code != CODE_NONE)
                begin
                    if (rel)
                    begin
                        seq[n] = CODE_BREAK;
                        n++;
                    end
                    seq[n] = code;
                    n++;
                end
            end
        endcase
        return n;
    endfunction

    // Expand the event taken in this transfer into frames awaited on the master side
    task automatic queue_event();
        logic [7:0] seq [8];
        int         n;
        kind_t      kind;
        key_frame_t fr;
        kind = kind_t'(s_axis_tuser[1:0]);
        if (cur_lit_n >= 0)
        begin
            n = cur_lit_n;
            for (int k = 0; k < n; k++)
                seq[k] = cur_lit[8 * (n - 1 - k) +: 8];
        end
        else
        begin
            n = scan_sequence(kind, s_axis_tdata[7:0], s_axis_tdata[15:8],
                              s_axis_tuser[2], seq);
        end
        for (int k = 0; k < n; k++)
        begin
            fr.frame  = ps2_frame_of(seq[k]);
            fr.byte_v = seq[k];
            fr.last   = (k == n - 1);
            frames_due.push_back(fr);
        end
        events_taken++;
        kind_taken[kind]++;
    endtask

    task automatic check_frame();
        key_frame_t want;
        frames_seen++;
        if (frames_due.size() == 0)
        begin
            err_count++;
            if (err_count <= ERR_PRINTS)
                $display("%0t: unexpected frame: got frame=%03h byte=%02h last=%0b",
                         $time, m_axis_tdata[10:0], m_axis_tdata[18:11], m_axis_tlast);
            return;
        end
        want = frames_due.pop_front();
        if (m_axis_tdata[10:0] !== want.frame || m_axis_tdata[18:11] !== want.byte_v ||
            m_axis_tlast !== want.last)
        begin
            err_count++;
            if (err_count <= ERR_PRINTS)
                $display("%0t: frame/byte/last expected %03h/%02h/%0b, got %03h/%02h/%0b",
                         $time, want.frame, want.byte_v, want.last,
                         m_axis_tdata[10:0], m_axis_tdata[18:11], m_axis_tlast);
        end
    endtask

    // Both transfers are observed at the same rising edge; predict first so that
    // a frame can never be checked ahead of the event that caused it.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            queue_event();
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_frame();
    end

    // Receiver: now and then hold tready low for a burst, never in the quiet stretch
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Present one key event from a falling edge and hold it until the transfer.
    // Returns at the falling edge after the transfer, valid still high.
    task automatic send_key(input kind_t kind, input logic [7:0] pre, input logic [7:0] code,
                            input logic rel, input int lit_n, input logic [63:0] lit);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        cur_lit_n = lit_n;
        cur_lit   = lit;
        s_axis_tdata  <= {code, pre};
        s_axis_tuser  <= {rel, kind};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] seq [8];
        kind_t      kind;
        logic [7:0] pre;
        logic [7:0] code;
        logic       rel;
        int         pick;
        int         sent_bytes;

        repeat (RESET_CYC) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, every kind, the fixed sequences and the silent cases
        foreach (dir_rows[i])
            send_key(dir_rows[i].kind, dir_rows[i].pre, dir_rows[i].code, dir_rows[i].rel,
                     dir_rows[i].lit_n, dir_rows[i].lit);

        // Random: mostly mapped keys with the usual E0 prefix; silent events do not count
        sent_bytes = 0;
        while (sent_bytes < RAND_EVENTS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                kind = KIND_SINGLE;
            else if (pick < 7)
                kind = KIND_PAIR;
            else if (pick < 9)
                kind = KIND_PRTSC;
            else
                kind = KIND_PAUSE;
            pre  = (kind == KIND_PAIR && $urandom_range(0, 9) < 7) ? CODE_EXT
                                                                   : 8'($urandom_range(0, 255));
            code = 8'($urandom_range(0, 255));
            if (kind == KIND_SINGLE && $urandom_range(0, 15) == 0)
                code = CODE_NONE;
            rel  = 1'($urandom_range(0, 1));
            if (scan_sequence(kind, pre, code, rel, seq) > 0)
                sent_bytes++;
            if (sent_bytes >= QUIET_AFTER)
                quiet = 1'b1;
            send_key(kind, pre, code, rel, -1, 64'h0);
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give the pipeline time to show any stray frame
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Sent %0d key events (single %0d, pair %0d, print screen %0d, pause %0d).",
                 events_taken, kind_taken[KIND_SINGLE], kind_taken[KIND_PAIR],
                 kind_taken[KIND_PRTSC], kind_taken[KIND_PAUSE]);
        $display("Checked %0d frames, %0d mismatches.", frames_seen, err_count);
        if (err_count == 0)
            $display("** ps2_key_frame_encoder: PASSED **");
        else
            $display("** ps2_key_frame_encoder: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #(LIMIT_CYC * 2 * CLK_HALF);
        $display("Timeout with %0d frames still awaited.", frames_due.size());
        $display("** ps2_key_frame_encoder: FAILED **");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/pke_pkg.sv
rtl/core/pke_front.sv
rtl/core/pke_queue.sv
rtl/core/pke_back.sv
rtl/core/ps2_key_frame_encoder.sv
tb/sv/tb_top.sv
